FILE: rtl/core/bmp_pkg.sv
package bmp_pkg;

  // Image size limits, also the reset values of the limit registers
  localparam int MAX_WIDTH  = 320;
  localparam int MAX_HEIGHT = 240;

  localparam int LIMIT_W_BITS = 9;
  localparam int LIMIT_H_BITS = 8;
  localparam int CFG_DATA_W   = 9;

  // Header layout
  localparam logic [5:0] HDR_LAST   = 6'd53;
  localparam logic [31:0] HDR_LEN   = 32'd54;
  localparam logic [7:0] SIG_FIRST  = 8'h42;
  localparam logic [7:0] SIG_SECOND = 8'h4D;
  localparam logic [5:0] HB_SIG0    = 6'd0;
  localparam logic [5:0] HB_SIG1    = 6'd1;
  localparam logic [5:0] HB_OFF0    = 6'd10;
  localparam logic [5:0] HB_OFF1    = 6'd11;
  localparam logic [5:0] HB_OFF2    = 6'd12;
  localparam logic [5:0] HB_OFF3    = 6'd13;
  localparam logic [5:0] HB_WID0    = 6'd18;
  localparam logic [5:0] HB_WID1    = 6'd19;
  localparam logic [5:0] HB_HGT0    = 6'd22;
  localparam logic [5:0] HB_HGT1    = 6'd23;

  // Configuration register indexes
  localparam logic REG_WIDTH_LIMIT  = 1'b0;
  localparam logic REG_HEIGHT_LIMIT = 1'b1;

  // Command queue between parser and back end
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;
  localparam int CMD_CNT_W = 3;

  localparam int IDX_W = 17;

  typedef enum logic [1:0] {
    EV_PIXEL     = 2'd0,
    EV_HDR_OK    = 2'd1,
    EV_BAD_SIG   = 2'd2,
    EV_TOO_LARGE = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_IDLE   = 3'd4
  } phase_t;

  // One classified event from the parser
  typedef struct packed {
    ev_kind_t    kind;
    logic [15:0] color;
    logic [15:0] width;
    logic [15:0] height;
    logic        row_end;
    logic        last;
  } cmd_t;

  // One finished result
  typedef struct packed {
    ev_kind_t         kind;
    logic [IDX_W-1:0] index;
    logic [15:0]      color;
    logic [15:0]      width;
    logic [15:0]      height;
    logic             last;
  } res_t;

endpackage

FILE: rtl/core/bmp_front.sv
module bmp_front import bmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            byte_value,
  input  logic                  frame_start,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cmd_valid,
  output cmd_t                  cmd
);

  phase_t      phase, phase_next;
  logic [5:0]  header_count, header_count_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [31:0] data_offset, data_offset_next;
  logic [31:0] skip_count, skip_count_next;
  logic [15:0] row_count, row_count_next;
  logic [15:0] col_count, col_count_next;
  logic [1:0]  comp_idx, comp_idx_next;
  logic [7:0]  blue_byte, blue_byte_next;
  logic [7:0]  green_byte, green_byte_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        sig_ok, sig_ok_next;
  logic [LIMIT_W_BITS-1:0] width_limit;
  logic [LIMIT_H_BITS-1:0] height_limit;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_limit  <= LIMIT_W_BITS'(MAX_WIDTH);
      height_limit <= LIMIT_H_BITS'(MAX_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH_LIMIT:  width_limit  <= cfg_data[LIMIT_W_BITS-1:0];
        REG_HEIGHT_LIMIT: height_limit <= cfg_data[LIMIT_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      width_reg    <= '0;
      height_reg   <= '0;
      data_offset  <= '0;
      skip_count   <= '0;
      row_count    <= '0;
      col_count    <= '0;
      comp_idx     <= '0;
      blue_byte    <= '0;
      green_byte   <= '0;
      pad_count    <= '0;
      sig_ok       <= 1'b1;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      data_offset  <= data_offset_next;
      skip_count   <= skip_count_next;
      row_count    <= row_count_next;
      col_count    <= col_count_next;
      comp_idx     <= comp_idx_next;
      blue_byte    <= blue_byte_next;
      green_byte   <= green_byte_next;
      pad_count    <= pad_count_next;
      sig_ok       <= sig_ok_next;
    end
  end

  // Byte classification and next state
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    data_offset_next  = data_offset;
    skip_count_next   = skip_count;
    row_count_next    = row_count;
    col_count_next    = col_count;
    comp_idx_next     = comp_idx;
    blue_byte_next    = blue_byte;
    green_byte_next   = green_byte;
    pad_count_next    = pad_count;
    sig_ok_next       = sig_ok;
    cmd_valid         = 1'b0;
    cmd               = '0;

    if (accept) begin
      // new file restarts header parsing from any phase
      if (frame_start) begin
        phase_next        = PH_HEADER;
        header_count_next = '0;
        width_reg_next    = '0;
        height_reg_next   = '0;
        data_offset_next  = '0;
        sig_ok_next       = 1'b1;
      end

      case (phase_next)
        PH_HEADER: begin
          if (header_count_next == HB_SIG0 && byte_value != SIG_FIRST) sig_ok_next = 1'b0;
          if (header_count_next == HB_SIG1 && byte_value != SIG_SECOND) sig_ok_next = 1'b0;
          case (header_count_next)
            HB_OFF0: data_offset_next[7:0]   = data_offset_next[7:0] | byte_value;
            HB_OFF1: data_offset_next[15:8]  = data_offset_next[15:8] | byte_value;
            HB_OFF2: data_offset_next[23:16] = data_offset_next[23:16] | byte_value;
            HB_OFF3: data_offset_next[31:24] = data_offset_next[31:24] | byte_value;
            HB_WID0: width_reg_next[7:0]     = byte_value;
            HB_WID1: width_reg_next[15:8]    = byte_value;
            HB_HGT0: height_reg_next[7:0]    = byte_value;
            HB_HGT1: height_reg_next[15:8]   = byte_value;
            default: ;
          endcase

          if (header_count_next != HDR_LAST) begin
            header_count_next = header_count_next + 6'd1;
          end else begin
            header_count_next = '0;
            cmd_valid  = 1'b1;
            cmd.width  = width_reg_next;
            cmd.height = height_reg_next;
            if (!sig_ok_next) begin
              phase_next = PH_IDLE;
              cmd.kind   = EV_BAD_SIG;
            end else if (width_reg_next > 16'(width_limit) ||
                         height_reg_next > 16'(height_limit)) begin
              phase_next = PH_IDLE;
              cmd.kind   = EV_TOO_LARGE;
            end else begin
              cmd.kind = EV_HDR_OK;
              skip_count_next = (data_offset_next > HDR_LEN) ?
                                data_offset_next - HDR_LEN : '0;
              if (skip_count_next != '0) begin
                phase_next = PH_SKIP;
              end else if (width_reg_next == '0 || height_reg_next == '0) begin
                phase_next = PH_IDLE;
              end else begin
                row_count_next = height_reg_next - 16'd1;
                col_count_next = '0;
                comp_idx_next  = '0;
                phase_next     = PH_PIXEL;
              end
            end
          end
        end

        PH_SKIP: begin
          skip_count_next = skip_count - 32'd1;
          if (skip_count_next == '0) begin
            if (width_reg == '0 || height_reg == '0) begin
              phase_next = PH_IDLE;
            end else begin
              row_count_next = height_reg - 16'd1;
              col_count_next = '0;
              comp_idx_next  = '0;
              phase_next     = PH_PIXEL;
            end
          end
        end

        PH_PIXEL: begin
          case (comp_idx)
            2'd0: begin
              blue_byte_next = byte_value;
              comp_idx_next  = 2'd1;
            end
            2'd1: begin
              green_byte_next = byte_value;
              comp_idx_next   = 2'd2;
            end
            default: begin
              comp_idx_next = '0;
              cmd_valid     = 1'b1;
              cmd.kind      = EV_PIXEL;
              cmd.color     = {byte_value[7:3], green_byte[7:2], blue_byte[7:3]};
              cmd.width     = width_reg;
              cmd.height    = height_reg;
              if ({1'b0, col_count} + 17'd1 < {1'b0, width_reg}) begin
                col_count_next = col_count + 16'd1;
              end else if (row_count == '0) begin
                cmd.last   = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                cmd.row_end    = 1'b1;
                row_count_next = row_count - 16'd1;
                pad_count_next = width_reg[1:0];
                if (width_reg[1:0] != 2'd0) begin
                  phase_next = PH_PAD;
                end else begin
                  col_count_next = '0;
                  comp_idx_next  = '0;
                  phase_next     = PH_PIXEL;
                end
              end
            end
          endcase
        end

        PH_PAD: begin
          pad_count_next = pad_count - 2'd1;
          if (pad_count_next == 2'd0) begin
            col_count_next = '0;
            comp_idx_next  = '0;
            phase_next     = PH_PIXEL;
          end
        end

        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/bmp_cmd_queue.sv
module bmp_cmd_queue import bmp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic not_empty,
  output logic is_full
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign is_full   = (count == CMD_CNT_W'(CMD_DEPTH));
  assign rd_data   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && is_full && !rd_en))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("command queue read while empty");

  a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count != CMD_CNT_W'(CMD_DEPTH)) |-> (wr_ptr - rd_ptr == count[CMD_PTR_W-1:0]))
    else $error("command queue count and pointers disagree");
`endif

endmodule

FILE: rtl/core/bmp_back.sv
module bmp_back import bmp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_avail,
  input  cmd_t cmd,
  output logic cmd_take,
  input  logic res_pop,
  output logic res_empty,
  output res_t res
);

  logic [IDX_W-1:0] pix_idx, pix_idx_next;
  logic [IDX_W-1:0] base_idx;
  logic [15:0]      top_row;
  logic [31:0]      base_prod;
  res_t             res_q [2];
  logic             head;
  logic [1:0]       count;
  logic             do_pop;
  res_t             res_new;

  assign cmd_take  = cmd_avail && (count != 2'd2);
  assign do_pop    = res_pop && (count != 2'd0);
  assign res_empty = (count == 2'd0);
  assign res       = res_q[head];

  // First pixel of the image sits in the bottom row: (height-1)*width
  assign top_row   = cmd.height - 16'd1;
  assign base_prod = top_row * cmd.width;
  assign base_idx  = base_prod[IDX_W-1:0];

  // Result build and running pixel index
  always_comb begin
    res_new        = '0;
    res_new.kind   = cmd.kind;
    res_new.color  = cmd.color;
    res_new.width  = cmd.width;
    res_new.height = cmd.height;
    res_new.last   = cmd.last;
    pix_idx_next   = pix_idx;
    case (cmd.kind)
      EV_PIXEL: begin
        res_new.index = pix_idx;
        // row end steps back over this row and the next one
        if (cmd.row_end)
          pix_idx_next = pix_idx - {cmd.width[IDX_W-2:0], 1'b0} + IDX_W'(1);
        else
          pix_idx_next = pix_idx + IDX_W'(1);
      end
      EV_HDR_OK: pix_idx_next = base_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_idx <= '0;
    end else if (cmd_take) begin
      pix_idx <= pix_idx_next;
    end
  end

  // Two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= '0;
    end else begin
      if (do_pop) head <= ~head;
      if (cmd_take && !do_pop) count <= count + 2'd1;
      else if (do_pop && !cmd_take) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) res_q[head ^ count[0]] <= res_new;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output queue count out of range");

  a_hdr_index_zero: assert property (@(posedge clk) disable iff (rst)
    (!res_empty && res.kind != EV_PIXEL) |-> (res.index == '0 && !res.last))
    else $error("header event carries pixel fields");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (!res_empty && !res_pop) |=> $stable(res))
    else $error("waiting result changed");
`endif

endmodule

FILE: rtl/core/bmp24_to_rgb565_stream_decoder_top.sv
// 24-bit BMP stream to RGB565 pixel decoder.
// Input channel: one file byte per transfer (byte_value), frame_start high
// on the first byte of a file; a transfer happens when push is high and
// full is low. Output channel: a queue read port; while empty is low the
// oldest result is on event_kind, pixel_index, pixel_color, image_width,
// image_height and last_pixel, and pop takes it.
// Each 54-byte header gives one event (accepted, bad signature or too
// large), then each blue/green/red triple gives one pixel event, rows
// bottom-up; bytes up to the data offset and row padding give nothing.
// Limits are written through cfg_write/cfg_index/cfg_data (index 0 width,
// index 1 height); the user must write them only while the decoder is
// idle, as the block does not enforce this. Throughput: one byte per
// clock while full is low, set by the parser that classifies a byte in
// the cycle it is taken; results pass the command, then the output queue.
// Reset (rst, synchronous): header phase, limits 320 x 240, queues empty.
// When the receiver stops popping, the 2-entry output queue and 4-entry
// command queue fill, then full rises and input stops; nothing is lost.
module bmp24_to_rgb565_stream_decoder_top import bmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            byte_value,
  input  logic                  frame_start,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            event_kind,
  output logic [IDX_W-1:0]      pixel_index,
  output logic [15:0]           pixel_color,
  output logic [15:0]           image_width,
  output logic [15:0]           image_height,
  output logic                  last_pixel,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_avail;
  logic cmd_take;
  res_t res;

  assign accept = push && !full;

  bmp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_value  (byte_value),
    .frame_start (frame_start),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_in)
  );

  bmp_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_valid),
    .wr_data   (cmd_in),
    .rd_en     (cmd_take),
    .rd_data   (cmd_head),
    .not_empty (cmd_avail),
    .is_full   (full)
  );

  bmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (cmd_avail),
    .cmd       (cmd_head),
    .cmd_take  (cmd_take),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign event_kind   = res.kind;
  assign pixel_index  = res.index;
  assign pixel_color  = res.color;
  assign image_width  = res.width;
  assign image_height = res.height;
  assign last_pixel   = res.last;

endmodule
